FILE: hdl/fcg_pkg.sv
// ----------------------------------------------------------------------------
// fcg_pkg
// Shared widths, register codes, types and the divide step of the
// four-corner gradient pixel generator.
// ----------------------------------------------------------------------------
package fcg_pkg;

    localparam int CH_BITS        = 8;
    localparam int RGB_BITS       = 3 * CH_BITS;
    localparam int DIM_BITS       = 13;
    localparam int COORD_BITS     = 12;
    localparam int CFG_IDX_BITS   = 3;
    localparam int SPAN_BITS      = DIM_BITS + CH_BITS;
    localparam int DIV_BITS       = 2 * DIM_BITS;
    localparam int NUM_BITS       = DIV_BITS + CH_BITS;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = CH_BITS / BITS_PER_STAGE;
    localparam int FRONT_STAGES   = 3;
    localparam int NUM_STAGES     = FRONT_STAGES + DIV_STAGES;

    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(480);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_UPPER_LEFT  = 3'd0,
        REG_UPPER_RIGHT = 3'd1,
        REG_LOWER_LEFT  = 3'd2,
        REG_LOWER_RIGHT = 3'd3,
        REG_WIDTH       = 3'd4,
        REG_HEIGHT      = 3'd5
    } reg_idx_t;

    // Index 2 is red, 1 green, 0 blue.
    typedef logic [2:0][CH_BITS-1:0] rgb_t;

    typedef struct packed {
        rgb_t                ul;
        rgb_t                ur;
        rgb_t                ll;
        rgb_t                lr;
        logic [DIM_BITS-1:0] width;
        logic [DIM_BITS-1:0] height;
        logic [DIM_BITS-1:0] w1;
        logic [DIM_BITS-1:0] h1;
        logic [DIV_BITS-1:0] divisor;
    } cfg_t;

    typedef struct packed {
        logic                q;
        logic [NUM_BITS-1:0] rem;
    } div_step_t;

    function automatic div_step_t div_step(input logic [NUM_BITS-1:0] rem,
                                           input logic [DIV_BITS-1:0] d,
                                           input int unsigned         sh);
        logic [NUM_BITS-1:0] trial;
        div_step_t           r;
        trial = NUM_BITS'(d) << sh;
        if (rem >= trial)
        begin
            r.q   = 1'b1;
            r.rem = rem - trial;
        end
        else
        begin
            r.q   = 1'b0;
            r.rem = rem;
        end
        return r;
    endfunction

endpackage

FILE: hdl/fcg_cfg_if.sv
// ----------------------------------------------------------------------------
// fcg_cfg_if
// Register write channel: index and data with valid/ready.
// ----------------------------------------------------------------------------
interface fcg_cfg_if;
    import fcg_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [RGB_BITS-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/fcg_in_if.sv
// ----------------------------------------------------------------------------
// fcg_in_if
// Pixel coordinate channel: column and row with valid/ready.
// ----------------------------------------------------------------------------
interface fcg_in_if;
    import fcg_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;

    modport source (output valid, output column, output row, input ready);
    modport sink   (input valid, input column, input row, output ready);
endinterface

FILE: hdl/fcg_out_if.sv
// ----------------------------------------------------------------------------
// fcg_out_if
// Pixel colour channel: red, green, blue and outside flag with valid/ready.
// ----------------------------------------------------------------------------
interface fcg_out_if;
    import fcg_pkg::*;

    logic               valid;
    logic               ready;
    logic [CH_BITS-1:0] red;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] blue;
    logic               outside_image;

    modport source (output valid, output red, output green, output blue,
                    output outside_image, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input outside_image, output ready);
endinterface

FILE: hdl/fcg_cfg.sv
// ----------------------------------------------------------------------------
// fcg_cfg
// Configuration registers: corner colours and image size, plus the spans
// (width-1 and height-1, at least one) and the registered divisor, their product.
// ----------------------------------------------------------------------------
module fcg_cfg (
    input  logic          clk,
    input  logic          rst_n,
    fcg_cfg_if.sink       cfg,
    output fcg_pkg::cfg_t cfg_out
);
    import fcg_pkg::*;

    rgb_t                ul_reg;
    rgb_t                ur_reg;
    rgb_t                ll_reg;
    rgb_t                lr_reg;
    logic [DIM_BITS-1:0] width_reg;
    logic [DIM_BITS-1:0] height_reg;
    logic [DIV_BITS-1:0] divisor_reg;
    logic [DIV_BITS-1:0] divisor_next;
    logic [DIM_BITS-1:0] w1;
    logic [DIM_BITS-1:0] h1;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ul_reg     <= '0;
            ur_reg     <= '0;
            ll_reg     <= '0;
            lr_reg     <= '0;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_UPPER_LEFT:  ul_reg     <= cfg.data;
                REG_UPPER_RIGHT: ur_reg     <= cfg.data;
                REG_LOWER_LEFT:  ll_reg     <= cfg.data;
                REG_LOWER_RIGHT: lr_reg     <= cfg.data;
                REG_WIDTH:       width_reg  <= cfg.data[DIM_BITS-1:0];
                REG_HEIGHT:      height_reg <= cfg.data[DIM_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // A span of zero stands in as one: its coordinate can only be zero.
    assign w1 = (width_reg  <= DIM_BITS'(1)) ? DIM_BITS'(1) : width_reg  - DIM_BITS'(1);
    assign h1 = (height_reg <= DIM_BITS'(1)) ? DIM_BITS'(1) : height_reg - DIM_BITS'(1);

    assign divisor_next = DIV_BITS'(w1) * DIV_BITS'(h1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            divisor_reg <= DIV_BITS'((WIDTH_RESET - DIM_BITS'(1)))
                         * DIV_BITS'((HEIGHT_RESET - DIM_BITS'(1)));
        else
            divisor_reg <= divisor_next;
    end

    assign cfg_out.ul      = ul_reg;
    assign cfg_out.ur      = ur_reg;
    assign cfg_out.ll      = ll_reg;
    assign cfg_out.lr      = lr_reg;
    assign cfg_out.width   = width_reg;
    assign cfg_out.height  = height_reg;
    assign cfg_out.w1      = w1;
    assign cfg_out.h1      = h1;
    assign cfg_out.divisor = divisor_reg;

endmodule

FILE: hdl/four_corner_gradient_pixel.sv
// ----------------------------------------------------------------------------
// four_corner_gradient_pixel
// Colour of one pixel of a bilinear blend of four corner colours.
//
//   port     dir  transaction
//   cfg      in   register index, write data
//   pix_in   in   column, row
//   pix_out  out  red, green, blue, outside_image
//
// One pixel per cycle unless pix_out stalls the pipe.
// Stages: range check, vertical blend, horizontal blend, then four stages of
// a restoring divider that resolve two quotient bits each.
// Each stage holds only while it is full and the stage after it holds, so
// bubbles close up under a stall. rst_n empties the pipe and loads the
// register reset values; the divisor follows a size write in the next cycle.
// ----------------------------------------------------------------------------
module four_corner_gradient_pixel (
    input  logic      clk,
    input  logic      rst_n,
    fcg_cfg_if.sink   cfg,
    fcg_in_if.sink    pix_in,
    fcg_out_if.source pix_out
);
    import fcg_pkg::*;

    cfg_t                 cfg_val;
    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] en;

    fcg_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_val)
    );

    // Stage enables: advance when empty or when the next stage advances.
    always_comb
    begin
        en[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || pix_out.ready;
        for (int s = NUM_STAGES - 2; s >= 0; s--)
            en[s] = !v_reg[s] || en[s+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= pix_in.valid;
            for (int s = 1; s < NUM_STAGES; s++)
                if (en[s])
                    v_reg[s] <= v_reg[s-1];
        end
    end

    assign pix_in.ready = en[0];

    // Stage 0: range check and spans.
    logic [COORD_BITS-1:0] x0_reg, y0_reg;
    logic [DIM_BITS-1:0]   wx0_reg, hy0_reg;
    logic                  out0_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x0_reg   <= pix_in.column;
            y0_reg   <= pix_in.row;
            wx0_reg  <= cfg_val.w1 - DIM_BITS'(pix_in.column);
            hy0_reg  <= cfg_val.h1 - DIM_BITS'(pix_in.row);
            out0_reg <= (DIM_BITS'(pix_in.column) >= cfg_val.width)
                     || (DIM_BITS'(pix_in.row) >= cfg_val.height);
        end
    end

    // Stage 1: vertical blend of the left and right edges.
    logic [COORD_BITS-1:0]           x1_reg;
    logic [DIM_BITS-1:0]             wx1_reg;
    logic                            out1_reg;
    logic [2:0][SPAN_BITS-1:0]       left1_reg, right1_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            x1_reg   <= x0_reg;
            wx1_reg  <= wx0_reg;
            out1_reg <= out0_reg;
            for (int c = 0; c < 3; c++)
            begin
                left1_reg[c]  <= SPAN_BITS'(hy0_reg) * SPAN_BITS'(cfg_val.ul[c])
                               + SPAN_BITS'(y0_reg)  * SPAN_BITS'(cfg_val.ll[c]);
                right1_reg[c] <= SPAN_BITS'(hy0_reg) * SPAN_BITS'(cfg_val.ur[c])
                               + SPAN_BITS'(y0_reg)  * SPAN_BITS'(cfg_val.lr[c]);
            end
        end
    end

    // Stage 2: horizontal blend; zero the numerator outside the image.
    logic [2:0][NUM_BITS-1:0] num2_reg;
    logic                     out2_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            out2_reg <= out1_reg;
            for (int c = 0; c < 3; c++)
                num2_reg[c] <= out1_reg ? '0
                             : NUM_BITS'(wx1_reg) * NUM_BITS'(left1_reg[c])
                             + NUM_BITS'(x1_reg)  * NUM_BITS'(right1_reg[c]);
        end
    end

    // Divide stages: two quotient bits each, most significant first.
    logic [DIV_STAGES-1:0][2:0][NUM_BITS-1:0] rem_reg;
    logic [DIV_STAGES-1:0][2:0][CH_BITS-1:0]  quo_reg;
    logic [DIV_STAGES-1:0]                    outd_reg;

    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_div
        logic [2:0][NUM_BITS-1:0] rem_in;
        logic [2:0][CH_BITS-1:0]  quo_in;
        logic                     out_in;
        logic [2:0][NUM_BITS-1:0] rem_next;
        logic [2:0][CH_BITS-1:0]  quo_next;

        if (j == 0)
        begin : g_first
            assign rem_in = num2_reg;
            assign quo_in = '0;
            assign out_in = out2_reg;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign quo_in = quo_reg[j-1];
            assign out_in = outd_reg[j-1];
        end

        always_comb
        begin
            div_step_t st;
            for (int c = 0; c < 3; c++)
            begin
                rem_next[c] = rem_in[c];
                quo_next[c] = quo_in[c];
                for (int b = 0; b < BITS_PER_STAGE; b++)
                begin
                    st = div_step(rem_next[c], cfg_val.divisor,
                                  CH_BITS - 1 - j * BITS_PER_STAGE - b);
                    rem_next[c] = st.rem;
                    quo_next[c][CH_BITS-1-j*BITS_PER_STAGE-b] = st.q;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[FRONT_STAGES+j])
            begin
                rem_reg[j]  <= rem_next;
                quo_reg[j]  <= quo_next;
                outd_reg[j] <= out_in;
            end
        end
    end

    assign pix_out.valid         = v_reg[NUM_STAGES-1];
    assign pix_out.red           = quo_reg[DIV_STAGES-1][2];
    assign pix_out.green         = quo_reg[DIV_STAGES-1][1];
    assign pix_out.blue          = quo_reg[DIV_STAGES-1][0];
    assign pix_out.outside_image = outd_reg[DIV_STAGES-1];

endmodule

FILE: dv/four_corner_gradient_pixel_checker.sv
// ----------------------------------------------------------------------------
// four_corner_gradient_pixel_checker
// Watches the register, coordinate and colour channels of the gradient
// generator. It keeps its own copy of the registers, computes the colour of
// every accepted coordinate transaction and compares each colour transaction
// field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module four_corner_gradient_pixel_checker (
    input  logic clk,
    input  logic rst_n,
    fcg_cfg_if   cfg,
    fcg_in_if    pix_in,
    fcg_out_if   pix_out,
    output int   mismatch_count,
    output int   pending_pixels,
    output int   checked_pixels,
    output int   outside_pixels
);
    import fcg_pkg::*;

    typedef struct packed {
        logic [CH_BITS-1:0] red;
        logic [CH_BITS-1:0] green;
        logic [CH_BITS-1:0] blue;
        logic               outside;
    } colour_t;

    logic [RGB_BITS-1:0] ul_rgb;
    logic [RGB_BITS-1:0] ur_rgb;
    logic [RGB_BITS-1:0] ll_rgb;
    logic [RGB_BITS-1:0] lr_rgb;
    logic [DIM_BITS-1:0] width_px;
    logic [DIM_BITS-1:0] height_px;

    colour_t expected_colours[$];
    int      errors;
    int      checked;
    int      outside;

    function automatic colour_t blend_pixel(input logic [COORD_BITS-1:0] col,
                                            input logic [COORD_BITS-1:0] row_px);
        colour_t            res;
        longint unsigned    x;
        longint unsigned    y;
        longint unsigned    span_x;
        longint unsigned    span_y;
        longint unsigned    left;
        longint unsigned    right;
        longint unsigned    quot;
        logic [CH_BITS-1:0] ch [3];
        int                 k;
        res = '0;
        x   = 64'(col);
        y   = 64'(row_px);
        if (x >= 64'(width_px) || y >= 64'(height_px))
        begin
            res.outside = 1'b1;
            return res;
        end
        // a single column or row spans nothing: blend with fraction 0
        span_x = (width_px == DIM_BITS'(1))  ? 64'd1 : 64'(width_px) - 64'd1;
        span_y = (height_px == DIM_BITS'(1)) ? 64'd1 : 64'(height_px) - 64'd1;
        for (k = 0; k < 3; k++)
        begin
            left  = (span_y - y) * 64'(ul_rgb[CH_BITS*k +: CH_BITS])
                  + y * 64'(ll_rgb[CH_BITS*k +: CH_BITS]);
            right = (span_y - y) * 64'(ur_rgb[CH_BITS*k +: CH_BITS])
                  + y * 64'(lr_rgb[CH_BITS*k +: CH_BITS]);
            quot  = ((span_x - x) * left + x * right) / (span_x * span_y);
            ch[k] = quot[CH_BITS-1:0];
        end
        res.red   = ch[2];
        res.green = ch[1];
        res.blue  = ch[0];
        return res;
    endfunction

    task automatic compare_field(input string label, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, label, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        colour_t want;
        colour_t got;
        if (!rst_n)
        begin
            ul_rgb    = '0;
            ur_rgb    = '0;
            ll_rgb    = '0;
            lr_rgb    = '0;
            width_px  = WIDTH_RESET;
            height_px = HEIGHT_RESET;
            expected_colours.delete();
            errors    = 0;
            checked   = 0;
            outside   = 0;
            mismatch_count <= 0;
            pending_pixels <= 0;
            checked_pixels <= 0;
            outside_pixels <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_UPPER_LEFT:  ul_rgb    = cfg.data;
                    REG_UPPER_RIGHT: ur_rgb    = cfg.data;
                    REG_LOWER_LEFT:  ll_rgb    = cfg.data;
                    REG_LOWER_RIGHT: lr_rgb    = cfg.data;
                    REG_WIDTH:       width_px  = cfg.data[DIM_BITS-1:0];
                    REG_HEIGHT:      height_px = cfg.data[DIM_BITS-1:0];
                    default:         ;
                endcase
            end
            if (pix_in.valid && pix_in.ready)
                expected_colours.push_back(blend_pixel(pix_in.column, pix_in.row));
            if (pix_out.valid && pix_out.ready)
            begin
                got = '{pix_out.red, pix_out.green, pix_out.blue, pix_out.outside_image};
                if (expected_colours.size() == 0)
                begin
                    errors++;
                    $display("%0t: colour transaction with nothing pending: %s",
                             $time, $sformatf("r %0d g %0d b %0d out %0b",
                             got.red, got.green, got.blue, got.outside));
                end
                else
                begin
                    want = expected_colours.pop_front();
                    checked++;
                    if (want.outside)
                        outside++;
                    compare_field("red", int'(want.red), int'(got.red));
                    compare_field("green", int'(want.green), int'(got.green));
                    compare_field("blue", int'(want.blue), int'(got.blue));
                    compare_field("outside_image", int'(want.outside), int'(got.outside));
                end
            end
            mismatch_count <= errors;
            pending_pixels <= expected_colours.size();
            checked_pixels <= checked;
            outside_pixels <= outside;
        end
    end

endmodule

FILE: dv/four_corner_gradient_pixel_tb.sv
// ----------------------------------------------------------------------------
// four_corner_gradient_pixel_tb
// Drives the gradient generator with register settings and pixel coordinates:
// a directed pass over corners, edges, one-pixel and empty images and oversize
// dimensions, then random settings with mostly in-image coordinates. Sender
// and receiver stall at random over the first 320 pixels only; the checker
// beside the block does the comparison and this module gives the verdict.
// ----------------------------------------------------------------------------
module four_corner_gradient_pixel_tb;
    import fcg_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO  = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI  = 3'd7;
    localparam int                      RANDOM_PIXELS = 410;
    localparam int                      PHASE_A_END   = 160;
    localparam int                      PHASE_B_END   = 320;

    logic clk;
    logic rst_n;
    int   sender_gap_pct     = 23;
    int   receiver_stall_pct = 73;
    int   pixels_sent        = 0;
    int   settings_used      = 0;
    int   random_target;
    int   mismatch_count;
    int   pending_pixels;
    int   checked_pixels;
    int   outside_pixels;
    int   width_sel;
    int   height_sel;

    fcg_cfg_if cfg_ch ();
    fcg_in_if  pix_in_ch ();
    fcg_out_if pix_out_ch ();

    four_corner_gradient_pixel u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .pix_in  (pix_in_ch),
        .pix_out (pix_out_ch)
    );

    four_corner_gradient_pixel_checker u_colour_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_ch),
        .pix_in         (pix_in_ch),
        .pix_out        (pix_out_ch),
        .mismatch_count (mismatch_count),
        .pending_pixels (pending_pixels),
        .checked_pixels (checked_pixels),
        .outside_pixels (outside_pixels)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        pix_out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            pix_out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [RGB_BITS-1:0]     value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    // dimension writes carry random junk above the 13 size bits
    task automatic configure(input logic [RGB_BITS-1:0] ul, input logic [RGB_BITS-1:0] ur,
                             input logic [RGB_BITS-1:0] ll, input logic [RGB_BITS-1:0] lr,
                             input logic [DIM_BITS-1:0] w,  input logic [DIM_BITS-1:0] h);
        logic [RGB_BITS-DIM_BITS-1:0] junk_w;
        logic [RGB_BITS-DIM_BITS-1:0] junk_h;
        junk_w = (RGB_BITS-DIM_BITS)'($urandom);
        junk_h = (RGB_BITS-DIM_BITS)'($urandom);
        write_reg(REG_WIDTH, {junk_w, w});
        write_reg(REG_HEIGHT, {junk_h, h});
        write_reg(REG_UPPER_LEFT, ul);
        write_reg(REG_UPPER_RIGHT, ur);
        write_reg(REG_LOWER_LEFT, ll);
        write_reg(REG_LOWER_RIGHT, lr);
        write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, RGB_BITS'($urandom));
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    task automatic send_pixel(input logic [COORD_BITS-1:0] col,
                              input logic [COORD_BITS-1:0] row_px);
        if (pixels_sent < PHASE_A_END)
        begin
            sender_gap_pct     = 23;
            receiver_stall_pct = 73;
        end
        else if (pixels_sent < PHASE_B_END)
        begin
            sender_gap_pct     = 73;
            receiver_stall_pct = 23;
        end
        else
        begin
            sender_gap_pct     = 0;
            receiver_stall_pct = 0;
        end
        while ($urandom_range(99) < sender_gap_pct)
        begin
            pix_in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_in_ch.valid  <= 1'b1;
        pix_in_ch.column <= col;
        pix_in_ch.row    <= row_px;
        do @(posedge clk); while (!pix_in_ch.ready);
        pixels_sent++;
    endtask

    // drop valid and hold until every colour transaction has come back
    task automatic drain();
        pix_in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_pixels != 0);
    endtask

    function automatic int pick_dim();
        case ($urandom_range(9))
            0:       return 1;
            1:       return 2;
            2:       return 4096;
            3:       return $urandom_range(8191, 4097);
            4:       return 0;
            5, 6:    return $urandom_range(4095, 3);
            default: return $urandom_range(64, 3);
        endcase
    endfunction

    function automatic logic [RGB_BITS-1:0] pick_rgb();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return RGB_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [COORD_BITS-1:0] pick_coord(input int dim);
        int span;
        span = (dim > 4096) ? 4096 : dim;
        if (span == 0)
            return COORD_BITS'($urandom_range(4095));
        case ($urandom_range(9))
            0:       return '0;
            1:       return COORD_BITS'(span - 1);
            2:       return (span < 4096) ? COORD_BITS'(span)
                                          : COORD_BITS'($urandom_range(4095));
            3:       return COORD_BITS'($urandom_range(4095));
            default: return COORD_BITS'($urandom_range(span - 1));
        endcase
    endfunction

    initial
    begin
        rst_n            <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= REG_UPPER_LEFT;
        cfg_ch.data      <= '0;
        pix_in_ch.valid  <= 1'b0;
        pix_in_ch.column <= '0;
        pix_in_ch.row    <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: 640 x 480, black corners
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd639, 12'd479);
        send_pixel(12'd640, 12'd0);
        send_pixel(12'd0, 12'd480);
        send_pixel(12'd4095, 12'd4095);
        drain();

        configure(24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF, 13'd4096, 13'd4096);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd2048, 12'd1024);
        send_pixel(12'hAAA, 12'h555);
        drain();

        configure(24'h123456, 24'h654321, 24'hABCDEF, 24'hFEDCBA, 13'd1, 13'd1);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd0);
        send_pixel(12'd0, 12'd1);
        drain();

        configure(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 13'd0, 13'd5);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd0, 12'd4);
        drain();

        configure(24'hFF00FF, 24'h00FFFF, 24'hFFFF00, 24'h808080, 13'd8191, 13'd2);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd4095, 12'd1);
        send_pixel(12'd0, 12'd2);
        drain();

        configure(24'h0000FF, 24'hFF0000, 24'h00FF00, 24'h000000, 13'd2, 13'd4096);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd4095);

        random_target = pixels_sent + RANDOM_PIXELS;
        while (pixels_sent < random_target)
        begin
            width_sel  = pick_dim();
            height_sel = pick_dim();
            drain();
            configure(pick_rgb(), pick_rgb(), pick_rgb(), pick_rgb(),
                      width_sel[DIM_BITS-1:0], height_sel[DIM_BITS-1:0]);
            repeat ($urandom_range(50, 20))
                send_pixel(pick_coord(width_sel), pick_coord(height_sel));
        end
        drain();
        repeat (NUM_STAGES + 4) @(posedge clk);

        $display("Checked %0d colour transactions, %0d of them outside the image,",
                 checked_pixels, outside_pixels);
        $display("over %0d settings; sizes ran from empty and one pixel to 8191.",
                 settings_used);
        if (mismatch_count == 0 && pending_pixels == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: sim.f
hdl/fcg_pkg.sv
hdl/fcg_cfg_if.sv
hdl/fcg_in_if.sv
hdl/fcg_out_if.sv
hdl/fcg_cfg.sv
hdl/four_corner_gradient_pixel.sv
dv/four_corner_gradient_pixel_checker.sv
dv/four_corner_gradient_pixel_tb.sv
